FILE: sv/sups_pkg.sv
`default_nettype none

package sups_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam int POS_BITS   = 6;
  localparam int COUNT_BITS = 7;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture item and compare against all entries
    logic resolve;  // reduce match flags to presence and position
    logic commit;   // shift entries, update count, write result
  } sups_cmd_t;

endpackage

`default_nettype wire

FILE: sv/sups_dp.sv
`default_nettype none

module sups_dp #(
  parameter int DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire sups_pkg::sups_cmd_t            cmd,
  input  wire logic [1:0]                     action,
  input  wire logic signed [31:0]             item_value,
  output logic [1:0]                          status,
  output logic                                was_present,
  output logic [sups_pkg::POS_BITS-1:0]       found_position,
  output logic [sups_pkg::COUNT_BITS-1:0]     entry_count
);
  import sups_pkg::*;

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PXW = (PW > POS_BITS) ? PW : POS_BITS;
  localparam int CXW = (CW > COUNT_BITS) ? CW : COUNT_BITS;

  logic signed [31:0] entries [DEPTH];
  logic signed [31:0] entries_next [DEPTH];
  logic [CW-1:0]      count;
  logic signed [31:0] value;
  logic [1:0]         act;
  logic [DEPTH-1:0]   gt;
  logic [DEPTH-1:0]   eq;
  logic [DEPTH-1:0]   gt_next;
  logic [DEPTH-1:0]   eq_next;
  logic               present;
  logic [PXW-1:0]     pos;
  logic [PXW-1:0]     pos_next;

  logic               full;
  logic               do_insert;
  logic               do_delete;
  logic [CW-1:0]      count_next;
  logic [1:0]         status_next;
  logic [CXW-1:0]     count_wide;

  // Each cell compares its own entry against the incoming value. Entries are
  // unique and descending, so gt is a thermometer and its edge is the slot.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int PREV = (g == 0) ? 0 : g - 1;
    localparam int NEXT = (g == DEPTH - 1) ? g : g + 1;
    logic live;

    assign live       = CW'(g) < count;
    assign gt_next[g] = live && (entries[g] > item_value);
    assign eq_next[g] = live && (entries[g] == item_value);

    always_comb begin
      entries_next[g] = entries[g];
      if (do_insert && !gt[g]) begin
        entries_next[g] = (g == 0 || gt[PREV]) ? value : entries[PREV];
      end else if (do_delete && !gt[g]) begin
        entries_next[g] = entries[NEXT];
      end
    end
  end

  always_comb begin
    pos_next = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (eq[i]) pos_next = pos_next | PXW'(i);
    end
  end

  assign full      = count == CW'(DEPTH);
  assign do_insert = cmd.commit && (act == ACT_INSERT) && !present && !full;
  assign do_delete = cmd.commit && (act == ACT_DELETE) && present;

  always_comb begin
    count_next = count;
    if (do_insert) count_next = count + 1'b1;
    if (do_delete) count_next = count - 1'b1;
  end

  always_comb begin
    case (act)
      ACT_INSERT: status_next = present ? ST_DUPLICATE : (full ? ST_FULL : ST_DONE);
      default:    status_next = present ? ST_DONE : ST_NOT_FOUND;
    endcase
  end

  assign count_wide = CXW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= item_value;
      act   <= action;
      gt    <= gt_next;
      eq    <= eq_next;
    end
    if (cmd.resolve) begin
      present <= |eq;
      pos     <= pos_next;
    end
    if (cmd.commit) begin
      entries        <= entries_next;
      status         <= status_next;
      was_present    <= present;
      found_position <= pos[POS_BITS-1:0];
      entry_count    <= count_wide[COUNT_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: sv/sups_ctrl.sv
`default_nettype none

module sups_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sups_pkg::sups_cmd_t      cmd
);
  import sups_pkg::*;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_RESOLVE = 2'd1;
  localparam logic [1:0] S_UPDATE  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  assign in_stall  = state != S_IDLE;
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.resolve = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_next  = S_UPDATE;
      end
      S_UPDATE: begin
        // hold until the result register can take the transaction
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/sorted_unique_priority_store_top.sv
// Each accepted transaction passes through compare, reduce and shift steps
// (states IDLE, RESOLVE, UPDATE); no new transaction is taken until the shift
// commits, which waits while out_stall holds the result register.
// Reset: synchronous, clears the entry count and control state; entry contents stay
// undefined until written and need no clearing pass.
`default_nettype none

module sorted_unique_priority_store_top #(
  parameter int STORE_DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 action,
  input  wire logic signed [31:0]         item_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      status,
  output logic                            was_present,
  output logic [sups_pkg::POS_BITS-1:0]   found_position,
  output logic [sups_pkg::COUNT_BITS-1:0] entry_count
);
  import sups_pkg::*;

  sups_cmd_t cmd;

  sups_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sups_dp #(
    .DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .action         (action),
    .item_value     (item_value),
    .status         (status),
    .was_present    (was_present),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sups_pkg::*;

  localparam int STORE_DEPTH   = 64;
  localparam int RANDOM_ITEMS  = 1630;
  localparam int POOL_SIZE     = 80;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 12;
  localparam int DIRECTED_ROWS = 22;

  // action code 3 is unused by the block and behaves as a lookup
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam int PHASE_FILL  = 0;
  localparam int PHASE_DRAIN = 1;
  localparam int PHASE_MIXED = 2;

  localparam int STALL_NONE     = 0;
  localparam int STALL_RANDOM   = 1;
  localparam int STALL_PERIODIC = 2;

  typedef struct packed {
    logic [1:0]            status;
    logic                  was_present;
    logic [POS_BITS-1:0]   found_position;
    logic [COUNT_BITS-1:0] entry_count;
  } op_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] val;
    logic        typed;
    op_result_t  want;
  } directed_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            action = ACT_LOOKUP;
  logic signed [31:0]    item_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            status;
  logic                  was_present;
  logic [POS_BITS-1:0]   found_position;
  logic [COUNT_BITS-1:0] entry_count;

  logic signed [31:0] ordered_values[$];  // descending, mirrors the store
  op_result_t         pending_results[$];
  op_result_t         oldest_result;
  logic [31:0]        value_pool[POOL_SIZE];
  int                 mismatches = 0;
  int                 cycle_count = 0;
  int                 burst_left = 0;
  int                 stall_mode = STALL_NONE;
  int                 stall_left = 0;

  directed_row_t directed_ops[DIRECTED_ROWS] = '{
    '{ACT_LOOKUP, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 1'b0, 6'd0, 7'd0}},
    '{ACT_DELETE, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 1'b0, 6'd0, 7'd0}},
    '{ACT_INSERT, 32'h7fff_ffff, 1'b1, '{ST_DONE, 1'b0, 6'd0, 7'd1}},
    '{ACT_INSERT, 32'h8000_0000, 1'b1, '{ST_DONE, 1'b0, 6'd0, 7'd2}},
    '{ACT_INSERT, 32'h7fff_ffff, 1'b1, '{ST_DUPLICATE, 1'b1, 6'd0, 7'd2}},
    '{ACT_LOOKUP, 32'h8000_0000, 1'b1, '{ST_DONE, 1'b1, 6'd1, 7'd2}},
    '{ACT_SPARE,  32'h8000_0000, 1'b1, '{ST_DONE, 1'b1, 6'd1, 7'd2}},
    '{ACT_INSERT, 32'h0000_0000, 1'b0, '0},
    '{ACT_INSERT, 32'hffff_ffff, 1'b0, '0},
    '{ACT_INSERT, 32'h0000_0001, 1'b0, '0},
    '{ACT_LOOKUP, 32'hffff_ffff, 1'b0, '0},
    '{ACT_SPARE,  32'h0000_0005, 1'b0, '0},
    '{ACT_DELETE, 32'h0000_0000, 1'b0, '0},
    '{ACT_DELETE, 32'h7fff_ffff, 1'b0, '0},
    '{ACT_DELETE, 32'h8000_0000, 1'b0, '0},
    '{ACT_DELETE, 32'h0001_2345, 1'b0, '0},
    '{ACT_INSERT, 32'h5555_5555, 1'b0, '0},
    '{ACT_INSERT, 32'haaaa_aaaa, 1'b0, '0},
    '{ACT_LOOKUP, 32'h5555_5555, 1'b0, '0},
    '{ACT_DELETE, 32'hffff_ffff, 1'b0, '0},
    '{ACT_INSERT, 32'h7fff_fffe, 1'b0, '0},
    '{ACT_DELETE, 32'h0000_0001, 1'b0, '0}
  };

  sorted_unique_priority_store_top #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .item_value    (item_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .was_present   (was_present),
    .found_position(found_position),
    .entry_count   (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one operation to the mirrored store and returns its outcome.
  function automatic op_result_t apply_store_op(logic [1:0] op, logic signed [31:0] val);
    op_result_t r;
    int hit;
    int slot;
    hit = -1;
    slot = 0;
    for (int i = 0; i < ordered_values.size(); i++) begin
      if (ordered_values[i] == val) begin
        hit = i;
        break;
      end
    end
    r.was_present    = (hit >= 0);
    r.found_position = (hit >= 0) ? POS_BITS'(hit) : '0;
    case (op)
      ACT_INSERT: begin
        if (hit >= 0) begin
          r.status = ST_DUPLICATE;
        end else if (ordered_values.size() >= STORE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          while (slot < ordered_values.size() && ordered_values[slot] > val) slot++;
          ordered_values.insert(slot, val);
          r.status = ST_DONE;
        end
      end
      ACT_DELETE: begin
        if (hit >= 0) begin
          ordered_values.delete(hit);
          r.status = ST_DONE;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: r.status = (hit >= 0) ? ST_DONE : ST_NOT_FOUND;
    endcase
    r.entry_count = COUNT_BITS'(ordered_values.size());
    return r;
  endfunction

  // Drives one transaction, waits for acceptance, records the expected outcome.
  // Valid stays high across a burst; between bursts it drops for a random gap.
  task automatic send_transaction(input logic [1:0] op, input logic [31:0] val,
                                  input logic typed, input op_result_t want);
    op_result_t predicted;
    action     <= op;
    item_value <= val;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_store_op(op, val);
    pending_results.push_back(typed ? want : predicted);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    int          sent;
    int          phase_kind;
    int          phase_len;
    int          pick;
    int          ins_pct;
    int          del_pct;
    int          vpick;
    logic [1:0]  op;
    logic [31:0] val;

    value_pool[0] = 32'h7fff_ffff;
    value_pool[1] = 32'h8000_0000;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    value_pool[4] = 32'h0000_0001;
    value_pool[5] = 32'h8000_0001;
    value_pool[6] = 32'h7fff_fffe;
    for (int i = 7; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_transaction(directed_ops[i].op, directed_ops[i].val,
                       directed_ops[i].typed, directed_ops[i].want);
    end

    // Phases lean toward filling or draining so the store swings between
    // empty and full; values mostly repeat so hits and duplicates are common.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_kind = $urandom_range(PHASE_FILL, PHASE_MIXED);
      phase_len  = $urandom_range(20, 140);
      case (phase_kind)
        PHASE_FILL:  begin ins_pct = 75; del_pct = 10; end
        PHASE_DRAIN: begin ins_pct = 15; del_pct = 65; end
        default:     begin ins_pct = 40; del_pct = 30; end
      endcase
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < ins_pct)                op = ACT_INSERT;
        else if (pick < ins_pct + del_pct) op = ACT_DELETE;
        else if (pick < 97)                op = ACT_LOOKUP;
        else                               op = ACT_SPARE;
        vpick = $urandom_range(0, 99);
        if (vpick < 35 && ordered_values.size() > 0)
          val = ordered_values[$urandom_range(0, ordered_values.size() - 1)];
        else if (vpick < 85)
          val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
          val = $urandom;
        send_transaction(op, val, 1'b0, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_unique_priority_store_top: match");
    end else begin
      $display("sorted_unique_priority_store_top: mismatch");
    end
    $finish;
  end

  // Receiver backpressure: alternates between no stall, random and periodic stall.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
      stall_left = $urandom_range(16, 160);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 40);
      default:      out_stall <= ((stall_left % 5) < 2);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with none outstanding");
        mismatches++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (status !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, status);
          mismatches++;
        end
        if (was_present !== oldest_result.was_present) begin
          $error("was_present: expected %0d, got %0d", oldest_result.was_present, was_present);
          mismatches++;
        end
        if (found_position !== oldest_result.found_position) begin
          $error("found_position: expected %0d, got %0d",
                 oldest_result.found_position, found_position);
          mismatches++;
        end
        if (entry_count !== oldest_result.entry_count) begin
          $error("entry_count: expected %0d, got %0d", oldest_result.entry_count, entry_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_unique_priority_store_top: mismatch");
      $finish;
    end
  end

endmodule

FILE: sim.f
sv/sups_pkg.sv
sv/sups_dp.sv
sv/sups_ctrl.sv
sv/sorted_unique_priority_store_top.sv
tb/testbench.sv
